/* sv/gpsm_pkg.sv */
// ----------------------------------------------------------------------------
// gpsm_pkg: shared types and constants for the gamepad poll serial master
// Phase and request codes, command bytes, timing reset values, byte count.
// ----------------------------------------------------------------------------
package gpsm_pkg;

  // Bytes kept per poll; the extended answer reads up to this many.
  localparam int unsigned MaxBytes = 9;
  localparam int unsigned MinBytes = 5;
  localparam int unsigned RxIdxW   = $clog2(MaxBytes);

  localparam logic [7:0]  CmdPoll = 8'h01;
  localparam logic [7:0]  CmdRead = 8'h42;
  localparam logic [7:0]  IdExt   = 8'h73;

  localparam logic [15:0] BitHalfReset = 16'd80;
  localparam logic [15:0] ByteGapReset = 16'd12000;

  // Configuration register indexes
  localparam logic CfgBitHalf = 1'b0;
  localparam logic CfgByteGap = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2,
    PH_GAP  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  // Command byte sent in exchange number idx
  function automatic logic [7:0] cmd_byte(input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx == 4'd0) begin
      b = CmdPoll;
    end else if (idx == 4'd1) begin
      b = CmdRead;
    end
    return b;
  endfunction

endpackage

/* sv/gamepad_poll_serial_master.sv */
// ----------------------------------------------------------------------------
// gamepad_poll_serial_master: tick-timed gamepad poll master
// Drives clock, command and attention for a full duplex LSB-first exchange,
// stores the received bytes and answers button queries.
// ----------------------------------------------------------------------------
//  channel   | direction | tuser         | tdata (lowest bit up)
//  s_axis    | in        | req_type      | data_line, button_byte, button_bit
//  m_axis    | out       | -             | clock_line, command_line,
//            |           |               | attention_line, busy_res,
//            |           |               | poll_done, button_pressed
//  cfg       | in        | write only    | 0 bit_half_ticks, 1 byte_gap_ticks
//
// One transaction per cycle while the output register is not stalled: state updates at
// the accepting edge and the result lands in the output register the same edge.
// Input is taken whenever the output register is empty or being drained.
// Reset idles the poll, clock and attention high, stored bytes zero.
// ----------------------------------------------------------------------------
module gamepad_poll_serial_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_line, button_byte[3:0], button_bit[2:0]
  input  logic [1:0]  s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // clock_line, command_line, attention_line,
                                        // busy_res, poll_done, button_pressed, 2'b0
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] bit_half_q, byte_gap_q;

  gpsm_pkg::phase_e phase_q, phase_d;
  logic [3:0]  byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;
  logic [15:0] wait_q, wait_d;
  logic [7:0]  tx_q, tx_d;
  logic [7:0]  rx_q, rx_d;
  logic        clk_line_q, clk_line_d;
  logic        cmd_line_q, cmd_line_d;
  logic        att_line_q, att_line_d;
  logic [7:0]  rcv_q [gpsm_pkg::MaxBytes];

  logic        rcv_we;
  logic        done, pressed;
  logic        accept;
  logic        out_valid_q;
  logic [7:0]  out_data_q;

  logic        data_line;
  logic [3:0]  button_byte;
  logic [2:0]  button_bit;
  logic [15:0] half_len;
  logic [2:0]  bit_nx;
  logic [4:0]  byte_nx;
  logic        ext_id;
  logic        more;
  logic [7:0]  first_tx;

  assign data_line   = s_axis_tdata_i[0];
  assign button_byte = s_axis_tdata_i[4:1];
  assign button_bit  = s_axis_tdata_i[7:5];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign half_len = (bit_half_q == 16'd0) ? 16'd1 : bit_half_q;
  assign bit_nx   = bit_q + 3'd1;
  assign byte_nx  = {1'b0, byte_q} + 5'd1;
  // byte 1 is stored on this very tick when it is the one finishing
  assign ext_id   = (byte_q == 4'd1) ? (rx_q == gpsm_pkg::IdExt)
                                     : (rcv_q[1] == gpsm_pkg::IdExt);
  assign more     = (byte_nx < 5'(gpsm_pkg::MinBytes)) ||
                    ((byte_nx < 5'(gpsm_pkg::MaxBytes)) && ext_id);

  always_comb begin
    phase_d    = phase_q;
    byte_d     = byte_q;
    bit_d      = bit_q;
    wait_d     = wait_q;
    tx_d       = tx_q;
    rx_d       = rx_q;
    clk_line_d = clk_line_q;
    cmd_line_d = cmd_line_q;
    att_line_d = att_line_q;
    rcv_we     = 1'b0;
    done       = 1'b0;
    pressed    = 1'b0;
    first_tx   = 8'h00;
    if (accept) begin
      case (s_axis_tuser_i)
        gpsm_pkg::REQ_TICK: begin
          case (phase_q)
            gpsm_pkg::PH_LOW: begin
              if (wait_q > 16'd1) begin
                wait_d = wait_q - 16'd1;
              end else begin
                if (data_line) begin
                  rx_d = rx_q | (8'd1 << bit_q);
                end
                clk_line_d = 1'b1;
                wait_d     = half_len;
                phase_d    = gpsm_pkg::PH_HIGH;
              end
            end
            gpsm_pkg::PH_HIGH: begin
              if (wait_q > 16'd1) begin
                wait_d = wait_q - 16'd1;
              end else if (bit_q != 3'd7) begin
                bit_d      = bit_nx;
                cmd_line_d = tx_q[bit_nx];
                clk_line_d = 1'b0;
                wait_d     = half_len;
                phase_d    = gpsm_pkg::PH_LOW;
              end else begin
                rcv_we = (byte_q < 4'(gpsm_pkg::MaxBytes)) ||
                         (gpsm_pkg::MaxBytes == 16);
                wait_d = 16'd0;
                if (more) begin
                  byte_d = byte_nx[3:0];
                  if (byte_gap_q == 16'd0) begin
                    first_tx   = gpsm_pkg::cmd_byte(byte_nx[3:0]);
                    tx_d       = first_tx;
                    rx_d       = 8'h00;
                    bit_d      = 3'd0;
                    cmd_line_d = first_tx[0];
                    clk_line_d = 1'b0;
                    wait_d     = half_len;
                    phase_d    = gpsm_pkg::PH_LOW;
                  end else begin
                    wait_d  = byte_gap_q;
                    phase_d = gpsm_pkg::PH_GAP;
                  end
                end else begin
                  att_line_d = 1'b1;
                  phase_d    = gpsm_pkg::PH_IDLE;
                  done       = 1'b1;
                end
              end
            end
            gpsm_pkg::PH_GAP: begin
              if (wait_q > 16'd1) begin
                wait_d = wait_q - 16'd1;
              end else begin
                first_tx   = gpsm_pkg::cmd_byte(byte_q);
                tx_d       = first_tx;
                rx_d       = 8'h00;
                bit_d      = 3'd0;
                cmd_line_d = first_tx[0];
                clk_line_d = 1'b0;
                wait_d     = half_len;
                phase_d    = gpsm_pkg::PH_LOW;
              end
            end
            default: begin
            end
          endcase
        end
        gpsm_pkg::REQ_START: begin
          // start while a poll runs is dropped
          if (phase_q == gpsm_pkg::PH_IDLE) begin
            first_tx   = gpsm_pkg::cmd_byte(4'd0);
            att_line_d = 1'b0;
            byte_d     = 4'd0;
            tx_d       = first_tx;
            rx_d       = 8'h00;
            bit_d      = 3'd0;
            cmd_line_d = first_tx[0];
            clk_line_d = 1'b0;
            wait_d     = half_len;
            phase_d    = gpsm_pkg::PH_LOW;
          end
        end
        gpsm_pkg::REQ_QUERY: begin
          if (5'(button_byte) < 5'(gpsm_pkg::MaxBytes)) begin
            pressed = !rcv_q[button_byte[gpsm_pkg::RxIdxW-1:0]][button_bit];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_half_q <= gpsm_pkg::BitHalfReset;
      byte_gap_q <= gpsm_pkg::ByteGapReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        gpsm_pkg::CfgBitHalf: bit_half_q <= cfg_wdata_i;
        gpsm_pkg::CfgByteGap: byte_gap_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= gpsm_pkg::PH_IDLE;
      byte_q     <= 4'd0;
      bit_q      <= 3'd0;
      wait_q     <= 16'd0;
      tx_q       <= 8'h00;
      rx_q       <= 8'h00;
      clk_line_q <= 1'b1;
      cmd_line_q <= 1'b0;
      att_line_q <= 1'b1;
    end else begin
      phase_q    <= phase_d;
      byte_q     <= byte_d;
      bit_q      <= bit_d;
      wait_q     <= wait_d;
      tx_q       <= tx_d;
      rx_q       <= rx_d;
      clk_line_q <= clk_line_d;
      cmd_line_q <= cmd_line_d;
      att_line_q <= att_line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gpsm_pkg::MaxBytes; i++) begin
        rcv_q[i] <= 8'h00;
      end
    end else if (rcv_we) begin
      rcv_q[byte_q[gpsm_pkg::RxIdxW-1:0]] <= rx_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {2'b00, pressed, done, (phase_d != gpsm_pkg::PH_IDLE),
                     att_line_d, cmd_line_d, clk_line_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

/* tb/gamepad_poll_serial_master_tb.sv */
// ----------------------------------------------------------------------------
// gamepad_poll_serial_master_tb: self-checking bench for the poll master
// Streams tick, start, query and no-op requests while a software gamepad
// answers on the data line. Every output transaction is compared field by
// field against an in-bench line predictor, under random source gaps and
// sink stalls, across several timing settings including both extremes.
// ----------------------------------------------------------------------------
module gamepad_poll_serial_master_tb;

  localparam logic [1:0]  ReqNone    = 2'd3;  // unused request code, must be a no-op
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned ReportMax  = 10;

  // Output tdata, lowest bit last in the list
  typedef struct packed {
    logic [1:0] pad;
    logic       pressed;
    logic       done;
    logic       busy;
    logic       att;
    logic       cmd;
    logic       clk;
  } poll_lines_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;  // data_line, button_byte[3:0], button_bit[2:0]
  logic [1:0]  s_axis_tuser_i  = '0;  // req_type
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // clock, command, attention, busy, done, pressed
  logic        cfg_we_i        = 1'b0;
  logic        cfg_addr_i      = 1'b0;
  logic [15:0] cfg_wdata_i     = '0;

  gamepad_poll_serial_master dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Predicted poll engine state
  gpsm_pkg::phase_e gp_phase;
  logic [3:0]  gp_byte;
  logic [2:0]  gp_bit;
  logic [15:0] gp_wait;
  logic [7:0]  gp_tx;
  logic [7:0]  gp_rx;
  logic [7:0]  gp_rx_mem [gpsm_pkg::MaxBytes];
  logic        gp_clk, gp_cmd, gp_att;
  logic [15:0] cfg_bit_half = gpsm_pkg::BitHalfReset;
  logic [15:0] cfg_byte_gap = gpsm_pkg::ByteGapReset;

  poll_lines_t pending_lines_q [$];
  bit          idle_on = 1'b1;
  int unsigned items_sent, polls_done, ext_polls, settings_cnt, mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned ready_hold;

  function automatic logic [15:0] half_ticks();
    return (cfg_bit_half == 16'd0) ? 16'd1 : cfg_bit_half;
  endfunction

  // Clock low half: present the next command bit
  function automatic void drive_bit();
    gp_cmd   = gp_tx[gp_bit];
    gp_clk   = 1'b0;
    gp_wait  = half_ticks();
    gp_phase = gpsm_pkg::PH_LOW;
  endfunction

  function automatic void open_byte();
    case (gp_byte)
      4'd0:    gp_tx = gpsm_pkg::CmdPoll;
      4'd1:    gp_tx = gpsm_pkg::CmdRead;
      default: gp_tx = 8'h00;
    endcase
    gp_rx  = 8'h00;
    gp_bit = 3'd0;
    drive_bit();
  endfunction

  function automatic bit wait_done();
    if (gp_wait > 16'd1) begin
      gp_wait = gp_wait - 16'd1;
      return 1'b0;
    end
    gp_wait = 16'd0;
    return 1'b1;
  endfunction

  function automatic poll_lines_t poll_predict(input logic [1:0] req, input logic data,
                                               input logic [3:0] bidx, input logic [2:0] bbit);
    poll_lines_t r;
    logic [4:0]  nxt;
    r = '0;
    case (req)
      gpsm_pkg::REQ_TICK: begin
        case (gp_phase)
          gpsm_pkg::PH_LOW: begin
            if (wait_done()) begin
              if (data) gp_rx[gp_bit] = 1'b1;
              gp_clk   = 1'b1;
              gp_wait  = half_ticks();
              gp_phase = gpsm_pkg::PH_HIGH;
            end
          end
          gpsm_pkg::PH_HIGH: begin
            if (wait_done()) begin
              if (gp_bit != 3'd7) begin
                gp_bit = gp_bit + 3'd1;
                drive_bit();
              end else begin
                if (gp_byte < gpsm_pkg::MaxBytes) gp_rx_mem[gp_byte] = gp_rx;
                nxt = {1'b0, gp_byte} + 5'd1;
                // extended answer is decided by the id byte just stored
                if (nxt < gpsm_pkg::MinBytes ||
                    (nxt < gpsm_pkg::MaxBytes && gp_rx_mem[1] == gpsm_pkg::IdExt)) begin
                  gp_byte = nxt[3:0];
                  if (cfg_byte_gap == 16'd0) begin
                    open_byte();
                  end else begin
                    gp_wait  = cfg_byte_gap;
                    gp_phase = gpsm_pkg::PH_GAP;
                  end
                end else begin
                  gp_att   = 1'b1;
                  gp_phase = gpsm_pkg::PH_IDLE;
                  r.done   = 1'b1;
                end
              end
            end
          end
          gpsm_pkg::PH_GAP: begin
            if (wait_done()) open_byte();
          end
          default: ;
        endcase
      end
      gpsm_pkg::REQ_START: begin
        if (gp_phase == gpsm_pkg::PH_IDLE) begin
          gp_att  = 1'b0;
          gp_byte = 4'd0;
          open_byte();
        end
      end
      gpsm_pkg::REQ_QUERY: begin
        if (bidx < gpsm_pkg::MaxBytes) r.pressed = ~gp_rx_mem[bidx][bbit];
      end
      default: ;
    endcase
    r.clk  = gp_clk;
    r.cmd  = gp_cmd;
    r.att  = gp_att;
    r.busy = (gp_phase != gpsm_pkg::PH_IDLE);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_item(input logic [1:0] req, input logic data,
                           input logic [3:0] bidx, input logic [2:0] bbit);
    int unsigned gap;
    poll_lines_t r;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {bbit, bidx, data};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = poll_predict(req, data, bidx, bbit);
    pending_lines_q.push_back(r);
    items_sent++;
    if (r.done) begin
      polls_done++;
      if (gp_byte == gpsm_pkg::MaxBytes - 1) ext_polls++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_lines_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [15:0] half, input logic [15:0] gap);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= gpsm_pkg::CfgBitHalf;
    cfg_wdata_i <= half;
    @(posedge clk_i);
    cfg_addr_i  <= gpsm_pkg::CfgByteGap;
    cfg_wdata_i <= gap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_bit_half = half;
    cfg_byte_gap = gap;
    settings_cnt++;
  endtask

  // One poll driven to completion; the gamepad answers with a random frame
  task automatic run_poll(input bit extended, input bit noisy);
    logic [7:0]  answer [gpsm_pkg::MaxBytes];
    int unsigned pick;
    logic        bit_in;
    for (int i = 0; i < gpsm_pkg::MaxBytes; i++) answer[i] = 8'($urandom);
    if (extended) answer[1] = gpsm_pkg::IdExt;
    else if (answer[1] == gpsm_pkg::IdExt) answer[1] = answer[1] ^ 8'h01;
    send_item(gpsm_pkg::REQ_START, 1'($urandom), 4'($urandom), 3'($urandom));
    while (gp_phase != gpsm_pkg::PH_IDLE) begin
      pick   = $urandom_range(0, 99);
      bit_in = (gp_phase == gpsm_pkg::PH_LOW) ? answer[gp_byte][gp_bit] : 1'($urandom);
      if (noisy && $urandom_range(0, 4) == 0) bit_in = 1'($urandom);
      if (pick < 86)
        send_item(gpsm_pkg::REQ_TICK, bit_in, 4'($urandom), 3'($urandom));
      else if (pick < 91)
        send_item(gpsm_pkg::REQ_QUERY, 1'($urandom), 4'($urandom), 3'($urandom));
      else if (pick < 95)
        send_item(gpsm_pkg::REQ_START, 1'($urandom), 4'($urandom), 3'($urandom));
      else if (pick < 98)
        send_item(ReqNone, 1'($urandom), 4'($urandom), 3'($urandom));
      else
        send_item(gpsm_pkg::REQ_TICK, 1'($urandom), 4'($urandom), 3'($urandom));
    end
  endtask

  task automatic test_idle_requests();
    send_item(gpsm_pkg::REQ_TICK, 1'b0, 4'd0, 3'd0);
    send_item(gpsm_pkg::REQ_TICK, 1'b1, 4'd15, 3'd7);
    send_item(gpsm_pkg::REQ_QUERY, 1'b0, 4'd0, 3'd0);
    send_item(gpsm_pkg::REQ_QUERY, 1'b1, 4'd8, 3'd7);
    send_item(gpsm_pkg::REQ_QUERY, 1'b0, 4'd4, 3'd3);
    send_item(gpsm_pkg::REQ_QUERY, 1'b0, 4'd9, 3'd0);   // first index past the store
    send_item(gpsm_pkg::REQ_QUERY, 1'b1, 4'd15, 3'd7);
    send_item(ReqNone, 1'b1, 4'd15, 3'd7);
    send_item(ReqNone, 1'b0, 4'd0, 3'd0);
    send_item(gpsm_pkg::REQ_TICK, 1'b1, 4'd10, 3'd5);
  endtask

  // Power-on timing through the first bit, then the poll is finished at fast timing
  task automatic test_reset_timing_poll();
    idle_on = 1'b0;
    send_item(gpsm_pkg::REQ_START, 1'($urandom), 4'($urandom), 3'($urandom));
    repeat (170) send_item(gpsm_pkg::REQ_TICK, 1'($urandom), 4'($urandom), 3'($urandom));
    idle_on = 1'b1;
    drain();
    set_timing(16'd1, 16'd1);
    run_poll(1'b0, 1'b0);
    drain();
  endtask

  // Zero half period behaves as one; zero gap chains bytes back to back
  task automatic test_zero_timing_extended();
    set_timing(16'd0, 16'd0);
    run_poll(1'b1, 1'b0);
    repeat (12) send_item(gpsm_pkg::REQ_QUERY, 1'($urandom), 4'($urandom_range(0, 9)),
                          3'($urandom));
    run_poll(1'b0, 1'b0);
    drain();
  endtask

  task automatic test_long_gap_poll();
    set_timing(16'd1, 16'd24);
    idle_on = 1'b0;
    run_poll(1'b0, 1'b0);
    idle_on = 1'b1;
    drain();
  endtask

  // Largest values loaded; only idle traffic, a poll here would run for millions of ticks
  task automatic test_max_half_idle();
    set_timing(16'hFFFF, 16'hFFFF);
    repeat (10) send_item(($urandom_range(0, 1) != 0) ? gpsm_pkg::REQ_QUERY
                                                      : gpsm_pkg::REQ_TICK,
                          1'($urandom), 4'($urandom), 3'($urandom));
    send_item(ReqNone, 1'($urandom), 4'($urandom), 3'($urandom));
    drain();
  endtask

  task automatic test_random_polls();
    int unsigned goal;
    for (int p = 0; p < 4; p++) begin
      drain();
      idle_on = (p != 2);
      set_timing(16'($urandom_range(0, 2)), (p == 1) ? 16'd0 : 16'($urandom_range(1, 6)));
      goal = items_sent + 100;
      while (items_sent < goal) begin
        // stray traffic, may open a poll that the next run_poll then finishes
        if ($urandom_range(0, 6) == 0)
          repeat ($urandom_range(1, 8))
            send_item(2'($urandom), 1'($urandom), 4'($urandom), 3'($urandom));
        run_poll(1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
      end
    end
    idle_on = 1'b1;
  endtask

  // Sink: runs of ready and stall of random length
  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready_i <= 1'b1;
      ready_hold      <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 9) < 7);
      ready_hold      <= pick_gap();
    end
  end

  task automatic flag_mismatch(input string what, input logic e, input logic a);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportMax)
      $display("mismatch on %s after %0d transactions: expected %b, got %b",
               what, items_sent, e, a);
  endtask

  always @(posedge clk_i) begin : check_outputs
    poll_lines_t want, got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = poll_lines_t'(m_axis_tdata_o);
      if (pending_lines_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ReportMax)
          $display("output transaction %h with nothing pending", m_axis_tdata_o);
      end else begin
        want = pending_lines_q.pop_front();
        if (got.clk !== want.clk) flag_mismatch("clock_line", want.clk, got.clk);
        if (got.cmd !== want.cmd) flag_mismatch("command_line", want.cmd, got.cmd);
        if (got.att !== want.att) flag_mismatch("attention_line", want.att, got.att);
        if (got.busy !== want.busy) flag_mismatch("busy_res", want.busy, got.busy);
        if (got.done !== want.done) flag_mismatch("poll_done", want.done, got.done);
        if (got.pressed !== want.pressed)
          flag_mismatch("button_pressed", want.pressed, got.pressed);
        if (got.pad !== 2'b00) flag_mismatch("tdata padding", 1'b0, |got.pad);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout, %0d transactions still pending", pending_lines_q.size());
      $display("[gamepad_poll_serial_master] ERROR");
      $finish;
    end
  end

  initial begin
    gp_phase = gpsm_pkg::PH_IDLE;
    gp_byte  = 4'd0;
    gp_bit   = 3'd0;
    gp_wait  = 16'd0;
    gp_tx    = 8'h00;
    gp_rx    = 8'h00;
    gp_clk   = 1'b1;
    gp_cmd   = 1'b0;
    gp_att   = 1'b1;
    for (int i = 0; i < gpsm_pkg::MaxBytes; i++) gp_rx_mem[i] = 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_requests();
    test_reset_timing_poll();
    test_zero_timing_extended();
    test_long_gap_poll();
    test_max_half_idle();
    test_random_polls();
    drain();

    $display("ran %0d transactions over %0d timing settings: %0d polls, %0d extended",
             items_sent, settings_cnt, polls_done, ext_polls);
    if (mismatch_cnt == 0 && pending_lines_q.size() == 0) begin
      $display("[gamepad_poll_serial_master] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, pending_lines_q.size());
      $display("[gamepad_poll_serial_master] ERROR");
    end
    $finish;
  end

endmodule
